// ===== sv/ordered_list_engine_unit_assert.svh =====
// Assertion helpers shared by the list engine RTL.
`ifndef ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define OLE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ole: implication check failed");

// next-cycle implication
`define OLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ole: next-cycle check failed");

`endif

// ===== sv/ole_pkg.sv =====
package ole_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int VALUE_W      = 32;
   localparam int COUNT_W      = 7;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      K_APPEND = 2'd0,
      K_DELETE = 2'd1,
      K_COUNT  = 2'd2,
      K_LIST   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

endpackage

// ===== sv/ole_ram.sv =====
module ole_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ole_front.sv =====
module ole_front import ole_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic signed [VALUE_W-1:0] req_item_value,
   output logic                      q_valid,
   output cmd_type                   q_cmd,
   input  logic                      q_pop
);

   cmd_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    new_cmd;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = ent_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.kind  = kind_type'(req_type);
      new_cmd.value = req_item_value;
      wr_ptr_in     = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in     = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in        = cnt_ff;
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== sv/ole_back.sv =====
module ole_back import ole_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  cmd_type                   q_cmd,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [COUNT_W-1:0]        rsp_match_count,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic                      rsp_last_flag
);

   localparam int PW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam logic [PW-1:0] NIL  = PW'(CAPACITY);
   localparam logic [PW-1:0] LAST = PW'(CAPACITY - 1);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_START    = 7'b0000010,
      S_APP_RD   = 7'b0000100,
      S_APP_WR   = 7'b0001000,
      S_APP_LINK = 7'b0010000,
      S_WALK     = 7'b0100000,
      S_DEL_FREE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in, free_ff, free_in;
   logic [PW-1:0] fresh_ff, fresh_in, len_ff, len_in;
   logic [PW-1:0] cur_ff, cur_in, prev_ff, prev_in, steps_ff, steps_in;
   logic [PW-1:0] node_ff, node_in, otail_ff, otail_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in, cnt_nx;

   logic                      ov_ff, ov_in;
   logic [1:0]                ost_ff, ost_in;
   logic [COUNT_W-1:0]        ocnt_ff, ocnt_in;
   logic signed [VALUE_W-1:0] oval_ff, oval_in;
   logic                      olast_ff, olast_in;

   logic [AW-1:0]      raddr, val_wa, link_wa;
   logic               val_we, link_we;
   logic [PW-1:0]      link_wd, link_rd;
   logic [VALUE_W-1:0] val_rd;

   logic out_free, emit, head_ok, tail_ok, free_ok, prev_ok, nx_ok, end_w, hit, advance;
   logic [1:0]                e_st;
   logic [COUNT_W-1:0]        e_cnt;
   logic signed [VALUE_W-1:0] e_val;
   logic                      e_last;

   ole_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (cmd_ff.value),
      .rd_addr (raddr),
      .rd_data (val_rd)
   );

   ole_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (raddr),
      .rd_data (link_rd)
   );

   assign out_free = !ov_ff || !rsp_stall;
   assign head_ok  = head_ff < NIL;
   assign tail_ok  = tail_ff < NIL;
   assign free_ok  = free_ff < NIL;
   assign prev_ok  = prev_ff < NIL;
   assign nx_ok    = link_rd < NIL;
   assign end_w    = !nx_ok || (steps_ff == LAST);
   assign hit      = (val_rd == cmd_ff.value);
   assign cnt_nx   = (hit && cnt_ff != COUNT_MAX) ? cnt_ff + COUNT_W'(1) : cnt_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      free_in  = free_ff;
      fresh_in = fresh_ff;
      len_in   = len_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      steps_in = steps_ff;
      node_in  = node_ff;
      otail_in = otail_ff;
      cnt_in   = cnt_ff;
      q_pop    = 1'b0;
      val_we   = 1'b0;
      val_wa   = node_ff[AW-1:0];
      link_we  = 1'b0;
      link_wa  = cur_ff[AW-1:0];
      link_wd  = NIL;
      raddr    = cur_ff[AW-1:0];
      emit     = 1'b0;
      e_st     = ST_OK;
      e_cnt    = '0;
      e_val    = cmd_ff.value;
      e_last   = 1'b1;
      advance  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = S_START;
            end
         end
         S_START: begin
            if (cmd_ff.kind == K_APPEND) begin
               if (len_ff == NIL || (!free_ok && fresh_ff >= NIL)) begin
                  if (out_free) begin
                     emit     = 1'b1;
                     e_st     = ST_FULL;
                     state_in = S_IDLE;
                  end
               end else if (free_ok) begin
                  raddr    = free_ff[AW-1:0];
                  node_in  = free_ff;
                  state_in = S_APP_RD;
               end else begin
                  node_in  = fresh_ff;
                  fresh_in = fresh_ff + PW'(1);
                  state_in = S_APP_WR;
               end
            end else if (!head_ok) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_st     = ST_EMPTY;
                  state_in = S_IDLE;
               end
            end else begin
               raddr    = head_ff[AW-1:0];
               cur_in   = head_ff;
               prev_in  = NIL;
               steps_in = '0;
               cnt_in   = '0;
               state_in = S_WALK;
            end
         end
         S_APP_RD: begin
            free_in  = link_rd;
            state_in = S_APP_WR;
         end
         S_APP_WR: begin
            if (out_free) begin
               val_we  = 1'b1;
               link_we = 1'b1;
               link_wa = node_ff[AW-1:0];
               emit    = 1'b1;
               tail_in = node_ff;
               len_in  = len_ff + PW'(1);
               if (!head_ok || !tail_ok) begin
                  head_in  = node_ff;
                  state_in = S_IDLE;
               end else begin
                  otail_in = tail_ff;
                  state_in = S_APP_LINK;
               end
            end
         end
         S_APP_LINK: begin
            link_we  = 1'b1;
            link_wa  = otail_ff[AW-1:0];
            link_wd  = node_ff;
            state_in = S_IDLE;
         end
         S_WALK: begin
            // one node per cycle while the result register is free; the read address follows the link just read
            if (out_free) begin
               case (cmd_ff.kind)
                  K_COUNT: begin
                     cnt_in = cnt_nx;
                     if (end_w) begin
                        emit     = 1'b1;
                        e_st     = (cnt_nx != '0) ? ST_OK : ST_NOTFOUND;
                        e_cnt    = cnt_nx;
                        state_in = S_IDLE;
                     end else begin
                        advance = 1'b1;
                     end
                  end
                  K_DELETE: begin
                     if (hit) begin
                        if (prev_ok) begin
                           link_we = 1'b1;
                           link_wa = prev_ff[AW-1:0];
                           link_wd = link_rd;
                        end else begin
                           head_in = link_rd;
                        end
                        if (tail_ff == cur_ff) begin
                           tail_in = prev_ff;
                        end
                        if (!prev_ok && !nx_ok) begin
                           tail_in = NIL;
                        end
                        if (len_ff != '0) begin
                           len_in = len_ff - PW'(1);
                        end
                        emit     = 1'b1;
                        state_in = S_DEL_FREE;
                     end else if (end_w) begin
                        emit     = 1'b1;
                        e_st     = ST_NOTFOUND;
                        state_in = S_IDLE;
                     end else begin
                        advance = 1'b1;
                     end
                  end
                  K_LIST: begin
                     emit   = 1'b1;
                     e_val  = val_rd;
                     e_last = end_w;
                     if (end_w) begin
                        state_in = S_IDLE;
                     end else begin
                        advance = 1'b1;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
            if (advance) begin
               raddr    = link_rd[AW-1:0];
               cur_in   = link_rd;
               prev_in  = cur_ff;
               steps_in = steps_ff + PW'(1);
            end
         end
         S_DEL_FREE: begin
            link_we  = 1'b1;
            link_wd  = free_ff;
            free_in  = cur_ff;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      ov_in    = ov_ff;
      ost_in   = ost_ff;
      ocnt_in  = ocnt_ff;
      oval_in  = oval_ff;
      olast_in = olast_ff;
      if (emit) begin
         ov_in    = 1'b1;
         ost_in   = e_st;
         ocnt_in  = e_cnt;
         oval_in  = e_val;
         olast_in = e_last;
      end else if (!rsp_stall) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      steps_ff <= steps_in;
      node_ff  <= node_in;
      otail_ff <= otail_in;
      cnt_ff   <= cnt_in;
      ost_ff   <= ost_in;
      ocnt_ff  <= ocnt_in;
      oval_ff  <= oval_in;
      olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= NIL;
         tail_ff  <= NIL;
         free_ff  <= NIL;
         fresh_ff <= '0;
         len_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
         fresh_ff <= fresh_in;
         len_ff   <= len_in;
         ov_ff    <= ov_in;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_status      = ost_ff;
   assign rsp_match_count = ocnt_ff;
   assign rsp_out_value   = oval_ff;
   assign rsp_last_flag   = olast_ff;

endmodule

// ===== sv/ordered_list_engine_unit.sv =====
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// request   | req_valid, req_stall | req_type, req_item_value
// result    | rsp_valid, rsp_stall | rsp_status, rsp_match_count, rsp_out_value,
//           |                      | rsp_last_flag
//
// Append runs start, a free-list read when a freed node is reused, the write and,
// for a non-empty list, a link of the old tail. Delete, count and list walk from
// the head, up to CAPACITY nodes, and delete then frees a matched node; the walk is set
// by one link RAM read per cycle. A 2-entry request queue lets new requests in meanwhile.
// Reset does no memory clearing pass. rsp_stall holds the walk in place while the result register is full.
`include "ordered_list_engine_unit_assert.svh"

module ordered_list_engine_unit import ole_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic signed [VALUE_W-1:0] req_item_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [COUNT_W-1:0]        rsp_match_count,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic                      rsp_last_flag
);

   logic    q_valid, q_pop;
   cmd_type q_cmd;

   ole_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_item_value (req_item_value),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop)
   );

   ole_back #(.CAPACITY(CAPACITY)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_match_count (rsp_match_count),
      .rsp_out_value   (rsp_out_value),
      .rsp_last_flag   (rsp_last_flag)
   );

   `OLE_ASSERT_IMPLY(a_pop_has_item, clock, reset, q_pop, q_valid)
   `OLE_ASSERT_IMPLY(a_err_is_last, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_last_flag)
   `OLE_ASSERT_IMPLY(a_count_ok, clock, reset, rsp_valid && rsp_match_count != '0, rsp_status == ST_OK)

endmodule
